[src/rle16_pixel_decoder_defines.svh]
// ----------------------------------------------------------------------------
// rle16_pixel_decoder_defines
// assertion macros shared by the rle16 pixel decoder modules
// ----------------------------------------------------------------------------
// each macro expects i_clk and i_rst_n in the module that uses it
`ifndef RLE16_PIXEL_DECODER_DEFINES_SVH
`define RLE16_PIXEL_DECODER_DEFINES_SVH

`ifndef SYNTH

// condition must hold whenever out of reset
`define RLD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RLD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RLD_ASSERT_ALWAYS(lbl, cond, msg)
`define RLD_ASSERT_IMPL(lbl, ante, cons, msg)
`define RLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/rld_pkg.sv]
// ----------------------------------------------------------------------------
// rld_pkg
// beat types and decoder constants for the rle16 pixel decoder
// ----------------------------------------------------------------------------
package rld_pkg;

    // opcode byte fields
    localparam logic [7:0] RUN_FLAG = 8'h80;

    // decoder phase codes
    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_LOW    = 2'd2;

    // one compressed byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } t_in_beat;

    // one decoded pixel with its repeat count
    typedef struct packed {
        logic [15:0] pixel_value;
        logic [6:0]  repeat_count;
        logic        from_run;
    } t_out_beat;

endpackage

[src/rld_in_reg.sv]
// ----------------------------------------------------------------------------
// rld_in_reg
// input register stage holding one compressed byte for the decoder
// ----------------------------------------------------------------------------
module rld_in_reg
    import rld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_beat o_beat,
    input  logic     i_take
);

    logic     r_valid;
    t_in_beat r_beat;

    // free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[src/rld_decode.sv]
// ----------------------------------------------------------------------------
// rld_decode
// opcode and pixel byte decoding with the run/literal state machine
// ----------------------------------------------------------------------------
`include "rle16_pixel_decoder_defines.svh"

module rld_decode
    import rld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    output logic      o_take,
    output logic      o_res_valid,
    output t_out_beat o_res,
    input  logic      i_res_ready
);

    logic [1:0] r_phase;
    logic [6:0] r_pixels_left;
    logic       r_in_run;
    logic [7:0] r_high_byte;

    logic [1:0] n_phase;
    logic [6:0] n_pixels_left;
    logic       n_in_run;
    logic [7:0] n_high_byte;

    logic [1:0] cur_phase;
    logic [6:0] cur_pixels_left;
    logic       cur_in_run;
    logic [7:0] cur_high_byte;
    logic [6:0] lit_left;
    logic       emit;

    // image start clears the state before the byte is decoded
    always_comb begin
        cur_phase       = i_beat.image_start ? PH_OPCODE : r_phase;
        cur_pixels_left = i_beat.image_start ? 7'd0 : r_pixels_left;
        cur_in_run      = i_beat.image_start ? 1'b0 : r_in_run;
        cur_high_byte   = i_beat.image_start ? 8'd0 : r_high_byte;
    end

    assign lit_left = cur_pixels_left - 7'd1;

    // next state and result for the byte at hand
    always_comb begin
        n_phase            = cur_phase;
        n_pixels_left      = cur_pixels_left;
        n_in_run           = cur_in_run;
        n_high_byte        = cur_high_byte;
        emit               = 1'b0;
        o_res.pixel_value  = {cur_high_byte, i_beat.data_byte};
        o_res.repeat_count = 7'd1;
        o_res.from_run     = 1'b0;
        unique case (cur_phase)
            PH_HIGH: begin
                n_high_byte = i_beat.data_byte;
                n_phase     = PH_LOW;
            end
            PH_LOW: begin
                if (cur_in_run) begin
                    n_pixels_left      = 7'd0;
                    n_phase            = PH_OPCODE;
                    emit               = (cur_pixels_left != 7'd0);
                    o_res.repeat_count = cur_pixels_left;
                    o_res.from_run     = 1'b1;
                end else begin
                    n_pixels_left = lit_left;
                    n_phase       = (lit_left != 7'd0) ? PH_HIGH : PH_OPCODE;
                    emit          = 1'b1;
                end
            end
            default: begin
                // opcode byte, also taken in the unused phase
                n_pixels_left = i_beat.data_byte[6:0];
                n_in_run      = ((i_beat.data_byte & RUN_FLAG) != 8'd0);
                n_phase       = (n_in_run || (n_pixels_left != 7'd0)) ? PH_HIGH : PH_OPCODE;
            end
        endcase
    end

    // a beat leaves once its result, if any, has somewhere to go
    assign o_take      = i_valid && (!emit || i_res_ready);
    assign o_res_valid = i_valid && emit;

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPCODE;
            r_pixels_left <= 7'd0;
            r_in_run      <= 1'b0;
            r_high_byte   <= 8'd0;
        end else if (o_take) begin
            r_phase       <= n_phase;
            r_pixels_left <= n_pixels_left;
            r_in_run      <= n_in_run;
            r_high_byte   <= n_high_byte;
        end
    end

    // checks
    `RLD_ASSERT_IMPL(a_emit_on_low, o_res_valid, cur_phase == PH_LOW, "pixel outside low phase")
    `RLD_ASSERT_IMPL(a_run_nonzero, o_res_valid && o_res.from_run, o_res.repeat_count != 7'd0,
        "run pixel with zero count")
    `RLD_ASSERT_IMPL(a_lit_single, o_res_valid && !o_res.from_run, o_res.repeat_count == 7'd1,
        "literal pixel repeat not one")

endmodule

[src/rld_out_reg.sv]
// ----------------------------------------------------------------------------
// rld_out_reg
// result register holding one decoded pixel until the receiver takes it
// ----------------------------------------------------------------------------
`include "rle16_pixel_decoder_defines.svh"

module rld_out_reg
    import rld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_beat i_beat,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_ready
);

    logic      r_valid;
    t_out_beat r_beat;
    logic      load;

    // free when empty or when the receiver drains it this cycle
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // checks
    `RLD_ASSERT_IMPL(a_no_overwrite, r_valid && !i_ready, !load, "held pixel overwritten")

endmodule

[src/rle16_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// rle16_pixel_decoder
// run-length decoder for a byte stream of 16-bit pixels
// ----------------------------------------------------------------------------
// Input channel: one compressed byte per beat (data_byte, image_start), with
// valid/ready. image_start on a beat clears the decoder and the byte is then
// read as an opcode. Output channel: one pixel per beat (pixel_value,
// repeat_count, from_run); a run gives one beat carrying its count, a literal
// gives one beat per pixel with count 1. Opcodes, high bytes and zero-length
// runs or literals give no output beat.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode pass between the input register and the result register.
// A byte accepted into the input register is decoded combinationally and its
// pixel is loaded into the result register, from which it is shown.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to expecting an opcode.
// When the receiver stalls the pixel holds in the result register, one more
// byte waits in the input register, and input ready drops only if that byte
// would produce a pixel.
// ----------------------------------------------------------------------------
module rle16_pixel_decoder
    import rld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_ready
);

    logic      stage_valid;
    t_in_beat  stage_beat;
    logic      stage_take;
    logic      res_valid;
    t_out_beat res_beat;
    logic      res_ready;

    // input register
    rld_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .o_ready (o_in_ready),
        .o_valid (stage_valid),
        .o_beat  (stage_beat),
        .i_take  (stage_take)
    );

    // decode pass
    rld_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_beat      (stage_beat),
        .o_take      (stage_take),
        .o_res_valid (res_valid),
        .o_res       (res_beat),
        .i_res_ready (res_ready)
    );

    // result register
    rld_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_beat  (res_beat),
        .o_ready (res_ready),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule
